[design/bfsw_pkg.sv]
// bfsw_pkg: shared constants, register codes and types of the span writer
// used by every module of the span writer and by its copy checker
// no dependencies
package bfsw_pkg;

	// window size and coordinate width
	localparam int WINDOW_ADDR_BITS = 16;
	localparam int COORD_BITS       = 12;

	// linear address: max row * max width + max column fits in 25 bits
	localparam int ADDR_W  = 25;
	localparam int BANK_W  = ADDR_W - WINDOW_ADDR_BITS;
	localparam int SHIFT_W = BANK_W + 7;

	localparam logic [11:0] COL_MASK = 12'((1 << COORD_BITS) - 1);

	// apb address width: six registers at 4-byte spacing
	localparam int PADDR_W = 5;

	// register map, index = byte address / 4
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH = 3'd0,
		REG_LAST_COLUMN  = 3'd1,
		REG_LAST_ROW     = 3'd2,
		REG_GRAN_SHIFT   = 3'd3,
		REG_BANK_EN      = 3'd4,
		REG_WRITE_WINDOW = 3'd5
	} reg_idx_t;

	// reset values of the registers
	localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;
	localparam logic [11:0] RST_LAST_COLUMN  = 12'd639;
	localparam logic [11:0] RST_LAST_ROW     = 12'd479;
	localparam logic [2:0]  RST_GRAN_SHIFT   = 3'd0;
	localparam logic        RST_BANK_EN      = 1'b1;
	localparam logic        RST_WRITE_WINDOW = 1'b0;

	// current configuration
	typedef struct packed {
		logic [12:0] screen_width;
		logic [11:0] last_column;
		logic [11:0] last_row;
		logic [2:0]  granularity_shift;
		logic        bank_switch_enable;
		logic        write_window;
	} cfg_t;

	// clipped span handed from the clip stage to the command stage
	typedef struct packed {
		logic              rect;
		logic              empty;
		logic [ADDR_W-1:0] start;
		logic [12:0]       len;
		logic [13:0]       col;
		logic [11:0]       row;
	} span_t;

endpackage

[design/bfsw_cfg_regs.sv]
// bfsw_cfg_regs: apb register file holding the screen and banking setup
// depends on bfsw_pkg (register codes, reset values, cfg_t)
module bfsw_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output bfsw_pkg::cfg_t                cfg
);

	bfsw_pkg::cfg_t     cfg_q;
	bfsw_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = bfsw_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width       <= bfsw_pkg::RST_SCREEN_WIDTH;
			cfg_q.last_column        <= bfsw_pkg::RST_LAST_COLUMN;
			cfg_q.last_row           <= bfsw_pkg::RST_LAST_ROW;
			cfg_q.granularity_shift  <= bfsw_pkg::RST_GRAN_SHIFT;
			cfg_q.bank_switch_enable <= bfsw_pkg::RST_BANK_EN;
			cfg_q.write_window       <= bfsw_pkg::RST_WRITE_WINDOW;
		end else if (wr_en) begin
			case (idx)
				bfsw_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[12:0];
				bfsw_pkg::REG_LAST_COLUMN:  cfg_q.last_column <= pwdata[11:0];
				bfsw_pkg::REG_LAST_ROW:     cfg_q.last_row <= pwdata[11:0];
				bfsw_pkg::REG_GRAN_SHIFT:   cfg_q.granularity_shift <= pwdata[2:0];
				bfsw_pkg::REG_BANK_EN:      cfg_q.bank_switch_enable <= pwdata[0];
				bfsw_pkg::REG_WRITE_WINDOW: cfg_q.write_window <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			bfsw_pkg::REG_SCREEN_WIDTH: prdata = 32'(cfg_q.screen_width);
			bfsw_pkg::REG_LAST_COLUMN:  prdata = 32'(cfg_q.last_column);
			bfsw_pkg::REG_LAST_ROW:     prdata = 32'(cfg_q.last_row);
			bfsw_pkg::REG_GRAN_SHIFT:   prdata = 32'(cfg_q.granularity_shift);
			bfsw_pkg::REG_BANK_EN:      prdata = 32'(cfg_q.bank_switch_enable);
			bfsw_pkg::REG_WRITE_WINDOW: prdata = 32'(cfg_q.write_window);
			default:                    prdata = '0;
		endcase
	end

endmodule

[design/bfsw_clip.sv]
// bfsw_clip: input register, screen clipping and linear start address
// depends on bfsw_pkg (cfg_t, span_t, ADDR_W)
module bfsw_clip (
	input  logic                clk,
	input  logic                arst_n,
	input  bfsw_pkg::cfg_t      cfg,
	input  logic                span_valid,
	output logic                span_ready,
	input  logic                start_of_rect,
	input  logic signed [12:0]  dest_x,
	input  logic signed [12:0]  dest_y,
	input  logic [11:0]         src_first,
	input  logic [11:0]         src_last,
	input  logic [11:0]         source_row,
	output logic                clip_vld,
	input  logic                clip_take,
	output bfsw_pkg::span_t     clip_span
);

	logic        valid_s1;
	logic        rect_s1;
	logic [12:0] dest_x_s1;
	logic [12:0] dest_y_s1;
	logic [11:0] src_first_s1;
	logic [11:0] src_last_s1;
	logic [11:0] row_s1;

	logic        row_off;
	logic        col_off;
	logic        reversed;
	logic [12:0] neg_x;
	logic [13:0] col0;
	logic [11:0] x0;
	logic [11:0] width_m1;
	logic [11:0] len_m1;
	logic [24:0] prod;

	assign span_ready = !valid_s1 || clip_take;
	assign clip_vld   = valid_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (span_ready) begin
			valid_s1 <= span_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (span_valid && span_ready) begin
			rect_s1      <= start_of_rect;
			dest_x_s1    <= dest_x;
			dest_y_s1    <= dest_y;
			src_first_s1 <= src_first;
			src_last_s1  <= src_last;
			row_s1       <= source_row;
		end
	end

	// clip against the visible screen and form the start address
	always_comb begin
		row_off = dest_y_s1[12] || (dest_y_s1[11:0] > cfg.last_row);
		col_off = !dest_x_s1[12] && (dest_x_s1[11:0] > cfg.last_column);
		neg_x   = 13'd0 - dest_x_s1;
		if (dest_x_s1[12]) begin
			col0 = 14'(src_first_s1) + 14'(neg_x);
			x0   = '0;
		end else begin
			col0 = 14'(src_first_s1);
			x0   = dest_x_s1[11:0];
		end
		reversed = 14'(src_last_s1) < col0;
		width_m1 = 12'(14'(src_last_s1) - col0);
		// trim the right end to the last visible column
		if ((13'(x0) + 13'(width_m1)) > 13'(cfg.last_column)) begin
			len_m1 = cfg.last_column - x0;
		end else begin
			len_m1 = width_m1;
		end
		prod = dest_y_s1[11:0] * cfg.screen_width;

		clip_span.rect  = rect_s1;
		clip_span.empty = row_off || col_off || reversed;
		clip_span.start = (bfsw_pkg::ADDR_W)'(prod) + (bfsw_pkg::ADDR_W)'(x0);
		clip_span.len   = 13'(len_m1) + 13'd1;
		clip_span.col   = col0;
		clip_span.row   = row_s1;
	end

endmodule

[design/bfsw_cmd.sv]
// bfsw_cmd: span register, bank split, bank tracking and result register
// depends on bfsw_pkg (cfg_t, span_t, window and bank widths, COL_MASK)
module bfsw_cmd (
	input  logic                clk,
	input  logic                arst_n,
	input  bfsw_pkg::cfg_t      cfg,
	input  logic                clip_vld,
	output logic                clip_take,
	input  bfsw_pkg::span_t     clip_span,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output logic                bank_change,
	output logic                window_select,
	output logic [13:0]         bank_value,
	output logic [15:0]         vram_offset,
	output logic [11:0]         src_column,
	output logic [11:0]         src_row_out,
	output logic [12:0]         span_length,
	output logic                last
);

	localparam int WIN = bfsw_pkg::WINDOW_ADDR_BITS;
	localparam int AW  = bfsw_pkg::ADDR_W;
	localparam int BW  = bfsw_pkg::BANK_W;

	bfsw_pkg::span_t span_s2;
	logic            valid_s2;
	logic            idx_q;
	logic [BW-1:0]   cur_bank_q;
	logic            known_q;

	logic            cmd_valid_q;
	logic            bank_change_q;
	logic            window_select_q;
	logic [13:0]     bank_value_q;
	logic [15:0]     vram_offset_q;
	logic [11:0]     src_column_q;
	logic [11:0]     src_row_q;
	logic [12:0]     span_length_q;
	logic            last_q;

	logic [BW-1:0]   bank0;
	logic [WIN-1:0]  off0;
	logic [AW-1:0]   end_addr;
	logic            split;
	logic [12:0]     first_len;
	logic [BW-1:0]   cmd_bank;
	logic [WIN-1:0]  cmd_off;
	logic [13:0]     cmd_col;
	logic [12:0]     cmd_len;
	logic            cmd_last;
	logic            known_eff;
	logic            change;
	logic [bfsw_pkg::SHIFT_W-1:0] shifted;
	logic            load;
	logic            done;

	// split the span at the window boundary and pick the current command
	always_comb begin
		bank0     = span_s2.start[AW-1:WIN];
		off0      = span_s2.start[WIN-1:0];
		end_addr  = span_s2.start + AW'(span_s2.len) - AW'(1);
		split     = end_addr[AW-1:WIN] != bank0;
		first_len = 13'((WIN+1)'(1 << WIN) - (WIN+1)'(off0));
		if (idx_q) begin
			cmd_bank = bank0 + BW'(1);
			cmd_off  = '0;
			cmd_col  = span_s2.col + 14'(first_len);
			cmd_len  = span_s2.len - first_len;
			cmd_last = 1'b1;
		end else begin
			cmd_bank = bank0;
			cmd_off  = off0;
			cmd_col  = span_s2.col;
			cmd_len  = split ? first_len : span_s2.len;
			cmd_last = !split;
		end
		// first command of a rectangle forgets the programmed bank
		known_eff = known_q && !(!idx_q && span_s2.rect);
		change    = cfg.bank_switch_enable && (!known_eff || (cmd_bank != cur_bank_q));
		shifted   = bfsw_pkg::SHIFT_W'(cmd_bank) << cfg.granularity_shift;
	end

	// load one command per cycle when the result register frees up
	assign load      = valid_s2 && !span_s2.empty && (!cmd_valid_q || cmd_ready);
	assign done      = valid_s2 && (span_s2.empty || (load && (idx_q == split)));
	assign clip_take = !valid_s2 || done;

	// span register and command index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 1'b0;
		end else begin
			if (clip_take) begin
				valid_s2 <= clip_vld;
			end
			if (done) begin
				idx_q <= 1'b0;
			end else if (load) begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clip_take && clip_vld) begin
			span_s2 <= clip_span;
		end
	end

	// last programmed bank, tracked in command order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_bank_q <= '0;
			known_q    <= 1'b0;
		end else if (load) begin
			cur_bank_q <= cmd_bank;
			known_q    <= 1'b1;
		end else if (done && span_s2.rect) begin
			known_q <= 1'b0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (load) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load) begin
			bank_change_q   <= change;
			window_select_q <= cfg.write_window;
			bank_value_q    <= 14'(shifted);
			vram_offset_q   <= 16'(cmd_off);
			src_column_q    <= cmd_col[11:0] & bfsw_pkg::COL_MASK;
			src_row_q       <= span_s2.row & bfsw_pkg::COL_MASK;
			span_length_q   <= cmd_len;
			last_q          <= cmd_last;
		end
	end

	assign cmd_valid     = cmd_valid_q;
	assign bank_change   = bank_change_q;
	assign window_select = window_select_q;
	assign bank_value    = bank_value_q;
	assign vram_offset   = vram_offset_q;
	assign src_column    = src_column_q;
	assign src_row_out   = src_row_q;
	assign span_length   = span_length_q;
	assign last          = last_q;

endmodule

[design/banked_framebuffer_span_writer.sv]
// banked_framebuffer_span_writer: top level of the span writer
// depends on bfsw_pkg, bfsw_cfg_regs, bfsw_clip, bfsw_cmd
//
// Usage:
// The span channel (span_valid/span_ready) takes one scanline span per
// transfer. The span is clipped to the visible screen, its linear start
// address is split into a 64 KiB bank and an offset, and one or two copy
// commands leave on the cmd channel (cmd_valid/cmd_ready); last marks the
// final command of a span. Spans that fall off screen produce no command.
// With banking on, bank_change is set when the bank differs from the
// one last programmed in the rectangle; start_of_rect forgets that bank.
// A span passes the input register, the span register and the result
// register before its first command is valid. Throughput: one command
// per cycle while cmd_ready is high, set by the command stage.
// Stalls: a held command blocks the command stage; the input register
// keeps taking one span until it is full, then span_ready drops.
// Reset: arst_n clears all valid flags and the bank tracking and loads
// the register defaults (640 wide, 639/479 last column/row, banking on).
// Registers must be written over the apb port only while the block is
// idle; the block itself does not enforce this.
module banked_framebuffer_span_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          span_valid,
	output logic                          span_ready,
	input  logic                          start_of_rect,
	input  logic signed [12:0]            dest_x,
	input  logic signed [12:0]            dest_y,
	input  logic [11:0]                   src_first,
	input  logic [11:0]                   src_last,
	input  logic [11:0]                   source_row,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output logic                          bank_change,
	output logic                          window_select,
	output logic [13:0]                   bank_value,
	output logic [15:0]                   vram_offset,
	output logic [11:0]                   src_column,
	output logic [11:0]                   src_row_out,
	output logic [12:0]                   span_length,
	output logic                          last
);

	bfsw_pkg::cfg_t  cfg;
	bfsw_pkg::span_t clip_span;
	logic            clip_vld;
	logic            clip_take;

	// configuration registers
	bfsw_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register and clipping
	bfsw_clip u_clip (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.span_valid    (span_valid),
		.span_ready    (span_ready),
		.start_of_rect (start_of_rect),
		.dest_x        (dest_x),
		.dest_y        (dest_y),
		.src_first     (src_first),
		.src_last      (src_last),
		.source_row    (source_row),
		.clip_vld      (clip_vld),
		.clip_take     (clip_take),
		.clip_span     (clip_span)
	);

	// bank split and command output
	bfsw_cmd u_cmd (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.clip_vld      (clip_vld),
		.clip_take     (clip_take),
		.clip_span     (clip_span),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.bank_change   (bank_change),
		.window_select (window_select),
		.bank_value    (bank_value),
		.vram_offset   (vram_offset),
		.src_column    (src_column),
		.src_row_out   (src_row_out),
		.span_length   (span_length),
		.last          (last)
	);

endmodule

[design/bfsw_checker.sv]
// bfsw_checker: port-level checks on the command channel of the span writer
// bound to banked_framebuffer_span_writer; no package dependency
module bfsw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        last,
	input logic [15:0] vram_offset,
	input logic [11:0] src_row_out
);

	// a stalled command holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(vram_offset) && $stable(last))
		else $error("stalled command changed");

	// the second half of a split span follows at once
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !last |=> cmd_valid && last)
		else $error("second command of split span missing");

	// second half starts at the window base
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !last |=> vram_offset == 16'd0)
		else $error("second command offset not zero");

	// both halves copy from the same source row
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !last |=> src_row_out == $past(src_row_out))
		else $error("source row changed within a span");

endmodule

bind banked_framebuffer_span_writer bfsw_checker u_bfsw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_ready   (cmd_ready),
	.last        (last),
	.vram_offset (vram_offset),
	.src_row_out (src_row_out)
);

[tb/bfsw_copy_checker.sv]
// bfsw_copy_checker: predicts the copy commands of the span writer and compares them
// watches the register port, the span channel and the cmd channel; depends on bfsw_pkg
`timescale 1ns / 100ps

module bfsw_copy_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	input  logic [31:0]                   prdata,
	input  logic                          pready,
	input  logic                          span_valid,
	input  logic                          span_ready,
	input  logic                          start_of_rect,
	input  logic signed [12:0]            dest_x,
	input  logic signed [12:0]            dest_y,
	input  logic [11:0]                   src_first,
	input  logic [11:0]                   src_last,
	input  logic [11:0]                   source_row,
	input  logic                          cmd_valid,
	input  logic                          cmd_ready,
	input  logic                          bank_change,
	input  logic                          window_select,
	input  logic [13:0]                   bank_value,
	input  logic [15:0]                   vram_offset,
	input  logic [11:0]                   src_column,
	input  logic [11:0]                   src_row_out,
	input  logic [12:0]                   span_length,
	input  logic                          last,
	output int                            pending,
	output int                            fail_count
);
	import bfsw_pkg::*;

	localparam int WIN_MASK = (1 << WINDOW_ADDR_BITS) - 1;

	// one copy command as it leaves the block
	typedef struct packed {
		logic        bank_change;
		logic        window_select;
		logic [13:0] bank_value;
		logic [15:0] vram_offset;
		logic [11:0] src_column;
		logic [11:0] src_row_out;
		logic [12:0] span_length;
		logic        last;
	} copy_cmd_t;

	cfg_t       cfg;
	logic       bank_known;
	int         cur_bank;
	int         err_cnt;
	copy_cmd_t  copy_q[$];
	copy_cmd_t  exp_cmd;

	// register image as read back over apb
	function automatic logic [31:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_SCREEN_WIDTH: return 32'(cfg.screen_width);
			REG_LAST_COLUMN:  return 32'(cfg.last_column);
			REG_LAST_ROW:     return 32'(cfg.last_row);
			REG_GRAN_SHIFT:   return 32'(cfg.granularity_shift);
			REG_BANK_EN:      return 32'(cfg.bank_switch_enable);
			REG_WRITE_WINDOW: return 32'(cfg.write_window);
			default:          return 32'd0;
		endcase
	endfunction

	function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	// one command: bank tracking decides whether the bank must be programmed
	task automatic push_copy(int bank, int off, int col, logic [11:0] row, int len,
			logic is_last);
		copy_cmd_t c;
		c.bank_change = (!bank_known || bank != cur_bank) ? cfg.bank_switch_enable : 1'b0;
		bank_known = 1'b1;
		cur_bank = bank;
		c.window_select = cfg.write_window;
		c.bank_value = 14'(bank << cfg.granularity_shift);
		c.vram_offset = 16'(off);
		c.src_column = 12'(col) & COL_MASK;
		c.src_row_out = row & COL_MASK;
		c.span_length = 13'(len);
		c.last = is_last;
		copy_q.push_back(c);
	endtask

	// clip one span to the screen and split it at a bank boundary
	task automatic plan_copies(logic sor, logic signed [12:0] dx, logic signed [12:0] dy,
			logic [11:0] sf, logic [11:0] sl, logic [11:0] sr);
		int x, y, xs, xe, len, start, bank, off, first_len;
		x = dx;
		y = dy;
		xs = int'(sf);
		xe = int'(sl);
		if (sor)
			bank_known = 1'b0;
		if (y < 0 || y > int'(cfg.last_row) || x > int'(cfg.last_column))
			return;
		// negative start moves the source start right
		if (x < 0) begin
			xs -= x;
			x = 0;
		end
		if (xe < xs)
			return;
		if (x + (xe - xs) > int'(cfg.last_column))
			xe = int'(cfg.last_column) - x + xs;
		if (xe < xs)
			return;
		len = xe - xs + 1;
		start = y * int'(cfg.screen_width) + x;
		bank = start >> WINDOW_ADDR_BITS;
		off = start & WIN_MASK;
		if (((start + len - 1) >> WINDOW_ADDR_BITS) == bank) begin
			push_copy(bank, off, xs, sr, len, 1'b1);
		end else begin
			first_len = WIN_MASK - off + 1;
			push_copy(bank, off, xs, sr, first_len, 1'b0);
			push_copy(bank + 1, 0, xs + first_len, sr, len - first_len, 1'b1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{RST_SCREEN_WIDTH, RST_LAST_COLUMN, RST_LAST_ROW, RST_GRAN_SHIFT,
				RST_BANK_EN, RST_WRITE_WINDOW};
			bank_known = 1'b0;
			cur_bank = 0;
			err_cnt = 0;
			copy_q.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			// register port: track writes, check read data
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_idx_t'(paddr[4:2]))
						REG_SCREEN_WIDTH: cfg.screen_width = pwdata[12:0];
						REG_LAST_COLUMN:  cfg.last_column = pwdata[11:0];
						REG_LAST_ROW:     cfg.last_row = pwdata[11:0];
						REG_GRAN_SHIFT:   cfg.granularity_shift = pwdata[2:0];
						REG_BANK_EN:      cfg.bank_switch_enable = pwdata[0];
						REG_WRITE_WINDOW: cfg.write_window = pwdata[0];
						default: ;
					endcase
				end else begin
					err_cnt += field_diff("prdata", reg_value(reg_idx_t'(paddr[4:2])), prdata);
				end
			end
			// command transfer against the oldest prediction
			if (cmd_valid && cmd_ready) begin
				if (copy_q.size() == 0) begin
					$error("copy command with no span waiting for it");
					err_cnt++;
				end else begin
					exp_cmd = copy_q.pop_front();
					err_cnt += field_diff("bank_change", exp_cmd.bank_change, bank_change);
					err_cnt += field_diff("window_select", exp_cmd.window_select, window_select);
					err_cnt += field_diff("bank_value", exp_cmd.bank_value, bank_value);
					err_cnt += field_diff("vram_offset", exp_cmd.vram_offset, vram_offset);
					err_cnt += field_diff("src_column", exp_cmd.src_column, src_column);
					err_cnt += field_diff("src_row_out", exp_cmd.src_row_out, src_row_out);
					err_cnt += field_diff("span_length", exp_cmd.span_length, span_length);
					err_cnt += field_diff("last", exp_cmd.last, last);
				end
			end
			// span transfer
			if (span_valid && span_ready)
				plan_copies(start_of_rect, dest_x, dest_y, src_first, src_last, source_row);
			pending <= copy_q.size();
			fail_count <= err_cnt;
		end
	end

endmodule

[tb/banked_framebuffer_span_writer_test.sv]
// banked_framebuffer_span_writer_test: stimulus and verdict for the span writer
// drives directed and random spans under several screen setups; depends on bfsw_pkg,
// banked_framebuffer_span_writer and bfsw_copy_checker
`timescale 1ns / 100ps

module banked_framebuffer_span_writer_test;
	import bfsw_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 span_valid = 1'b0;
	logic                 span_ready;
	logic                 start_of_rect = 1'b0;
	logic signed [12:0]   dest_x = '0;
	logic signed [12:0]   dest_y = '0;
	logic [11:0]          src_first = '0;
	logic [11:0]          src_last = '0;
	logic [11:0]          source_row = '0;
	logic                 cmd_valid;
	logic                 cmd_ready = 1'b0;
	logic                 bank_change;
	logic                 window_select;
	logic [13:0]          bank_value;
	logic [15:0]          vram_offset;
	logic [11:0]          src_column;
	logic [11:0]          src_row_out;
	logic [12:0]          span_length;
	logic                 last;

	int   pending;
	int   fail_count;

	// pacing of both sides: 0 no idling, 1 light, 2 heavy
	int   tx_mode = 1;
	int   rx_mode = 1;
	logic long_hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   rx_gap = 0;

	// screen geometry currently programmed, used to aim the spans
	int   cur_sw = 640;
	int   cur_lc = 639;
	int   cur_lr = 479;

	banked_framebuffer_span_writer i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.span_valid, .span_ready, .start_of_rect, .dest_x, .dest_y, .src_first,
		.src_last, .source_row, .cmd_valid, .cmd_ready, .bank_change, .window_select,
		.bank_value, .vram_offset, .src_column, .src_row_out, .span_length, .last
	);

	bfsw_copy_checker i_checker (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.span_valid, .span_ready, .start_of_rect, .dest_x, .dest_y, .src_first,
		.src_last, .source_row, .cmd_valid, .cmd_ready, .bank_change, .window_select,
		.bank_value, .vram_offset, .src_column, .src_row_out, .span_length, .last,
		.pending, .fail_count
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(3, 1);
		else if (r < 95)
			return $urandom_range(12, 4);
		return $urandom_range(80, 20);
	endfunction

	// cmd receiver: random gaps plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ready <= 1'b0;
		end else if (hold_left > 0) begin
			cmd_ready <= 1'b0;
			hold_left--;
		end else if (long_hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 400;
			cmd_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			cmd_ready <= 1'b0;
			rx_gap--;
		end else begin
			cmd_ready <= 1'b1;
			if (rx_mode != 0 && $urandom_range(99) < (rx_mode == 1 ? 15 : 50))
				rx_gap = idle_len();
		end
	end

	// one span transfer, then maybe an idle gap
	task automatic send_span(input logic sor, input int dx, input int dy, input int sf,
			input int sl, input int sr);
		int gap;
		span_valid <= 1'b1;
		start_of_rect <= sor;
		dest_x <= 13'(dx);
		dest_y <= 13'(dy);
		src_first <= 12'(sf);
		src_last <= 12'(sl);
		source_row <= 12'(sr);
		do @(posedge clk); while (!span_ready);
		if (tx_mode != 0 && $urandom_range(99) < (tx_mode == 1 ? 20 : 60)) begin
			gap = idle_len();
			span_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// random upper bits around a register value
	function automatic logic [31:0] with_junk(int v, int w);
		return ($urandom << w) | (v & ((1 << w) - 1));
	endfunction

	// stop sending and let every expected command drain
	task automatic settle_idle();
		span_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic program_screen(input int sw, input int lc, input int lr, input int gs,
			input int be, input int ww);
		settle_idle();
		reg_write(REG_SCREEN_WIDTH, with_junk(sw, 13));
		reg_write(REG_LAST_COLUMN, with_junk(lc, 12));
		reg_write(REG_LAST_ROW, with_junk(lr, 12));
		reg_write(REG_GRAN_SHIFT, with_junk(gs, 3));
		reg_write(REG_BANK_EN, with_junk(be, 1));
		reg_write(REG_WRITE_WINDOW, with_junk(ww, 1));
		for (int i = int'(REG_SCREEN_WIDTH); i <= int'(REG_WRITE_WINDOW); i++)
			reg_read(reg_idx_t'(i));
		cur_sw = sw;
		cur_lc = lc;
		cur_lr = lr;
	endtask

	function automatic int pick_last();
		case ($urandom_range(5))
			0: return 0;
			1: return 4095;
			2: return 639;
			default: return $urandom_range(4095);
		endcase
	endfunction

	// mostly rectangles of consecutive rows, some aimed at bank boundaries, rest noise
	task automatic run_random_spans(input int n);
		int sent, rows, x0, y0, s0, w, r0, k, pick;
		logic aim;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(99) < 80) begin
				rows = $urandom_range(8, 1);
				pick = $urandom_range(99);
				if (pick < 70)
					w = $urandom_range(64, 1);
				else if (pick < 90)
					w = $urandom_range(cur_lc + 1, 1);
				else
					w = $urandom_range(4096, 1);
				x0 = int'($urandom_range(cur_lc + 64)) - 64;
				y0 = $urandom_range(cur_lr);
				aim = (cur_sw != 0 && $urandom_range(3) == 0);
				// straddle a bank boundary on the first row
				if (aim) begin
					k = $urandom_range(8, 1);
					y0 = (k << WINDOW_ADDR_BITS) / cur_sw;
					x0 = (k << WINDOW_ADDR_BITS) - y0 * cur_sw - int'($urandom_range(w - 1));
					if (x0 > cur_lc || x0 < -64)
						x0 = int'($urandom_range(cur_lc + 64)) - 64;
				end
				s0 = $urandom_range(4095);
				r0 = $urandom_range(4095);
				for (int i = 0; i < rows && sent < n; i++) begin
					send_span(i == 0, x0, y0 + i, s0, s0 + w - 1, r0 + i);
					sent++;
				end
			end else begin
				send_span($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		int sw;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset values of the registers
		for (int i = int'(REG_SCREEN_WIDTH); i <= int'(REG_WRITE_WINDOW); i++)
			reg_read(reg_idx_t'(i));

		// directed spans at the reset screen setup
		send_span(1, 0, 0, 0, 9, 0);
		send_span(0, 0, 1, 0, 9, 1);
		send_span(0, 0, 102, 0, 4095, 4095);
		send_span(0, -100, 10, 50, 300, 7);
		send_span(0, -4096, 5, 0, 4095, 8);
		send_span(0, 0, -4096, 0, 10, 0);
		send_span(0, 0, 4095, 0, 10, 0);
		send_span(0, 0, 479, 0, 10, 0);
		send_span(0, 0, 480, 0, 10, 0);
		send_span(0, 640, 3, 0, 10, 0);
		send_span(0, 639, 3, 5, 5, 0);
		send_span(0, 4095, 3, 0, 10, 0);
		send_span(0, 10, 20, 100, 50, 0);
		// off-screen first row still forgets the bank
		send_span(1, -4096, -4096, 4095, 0, 0);
		send_span(0, 600, 200, 4095, 4095, 4095);
		send_span(0, -1, 30, 0, 4095, 123);

		// unbanked, largest shift, window b
		program_screen(640, 639, 479, 7, 0, 1);
		send_span(1, 0, 102, 0, 639, 0);
		send_span(0, 0, 300, 0, 9, 0);

		// zero screen width: address is just the column
		program_screen(0, 4095, 4095, 6, 1, 0);
		send_span(1, 4000, 4095, 0, 4095, 0);

		// widest screen, top bank
		program_screen(8191, 4095, 4095, 7, 1, 1);
		send_span(1, 4095, 4095, 0, 0, 4095);
		send_span(0, 0, 8, 0, 4095, 4095);

		// single pixel screen
		program_screen(1, 0, 0, 0, 1, 0);
		send_span(1, 0, 0, 0, 4095, 0);
		send_span(0, 0, 1, 0, 0, 0);
		send_span(0, -5, 0, 5, 9, 0);

		// random phases, the first one backs the block up with a long receiver stall
		for (int p = 0; p < 12; p++) begin
			if (p == 0) begin
				program_screen(640, 639, 479, 0, 1, 0);
				tx_mode = 0;
				rx_mode <= 1;
				long_hold_req <= 1'b1;
			end else begin
				case ($urandom_range(7))
					0: sw = 0;
					1: sw = 1;
					2: sw = 8191;
					3: sw = 4096;
					4: sw = 640;
					default: sw = $urandom_range(8191);
				endcase
				program_screen(sw, pick_last(), pick_last(), $urandom_range(7),
					$urandom_range(1), $urandom_range(1));
				tx_mode = $urandom_range(2);
				rx_mode <= $urandom_range(2);
			end
			run_random_spans(108);
		end

		// drain and give the verdict
		span_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
design/bfsw_pkg.sv
design/bfsw_cfg_regs.sv
design/bfsw_clip.sv
design/bfsw_cmd.sv
design/banked_framebuffer_span_writer.sv
design/bfsw_checker.sv
tb/bfsw_copy_checker.sv
tb/banked_framebuffer_span_writer_test.sv
